// ===== design/fwst_pkg.sv =====
// Package for the frame-rate window statistics block.
// Shared widths, constants, register indexes and types; no dependencies.
package fwst_pkg;

  // Field widths
  localparam int DUR_W   = 24;
  localparam int FPS_W   = 18;
  localparam int TIMER_W = 32;

  // Default window length
  localparam int HISTORY_DEPTH_DEF = 128;

  // Front queue between classification and processing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Rate arithmetic: rate = RATE_NUM / duration, in 1/16 fps
  localparam logic [DUR_W-1:0] RATE_NUM     = 24'd16000000;
  localparam logic [DUR_W-1:0] VALID_MIN_US = 24'd100;
  localparam logic [FPS_W-1:0] MIN_NONE     = 18'd160000;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;
  localparam logic                 ENABLE_RST   = 1'b1;
  localparam logic [DUR_W-1:0]     INTERVAL_RST = 24'd500000;

  // Head of the front queue as seen by the back end
  typedef struct packed {
    logic             valid;
    logic [DUR_W-1:0] dur;
  } q_head_t;

  // One report, lowest field last in the packed order
  typedef struct packed {
    logic [FPS_W-1:0] max_fps;
    logic [FPS_W-1:0] min_fps;
    logic [FPS_W-1:0] average_fps;
    logic [FPS_W-1:0] current_fps;
  } fps_report_t;

endpackage

// ===== design/fwst_front.sv =====
// Front end: accepts durations, drops them while disabled, queues the rest.
// Depends on fwst_pkg.
module fwst_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    enable,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [fwst_pkg::DUR_W-1:0] in_dur,
  output fwst_pkg::q_head_t       head,
  input  logic                    pop
);

  logic [fwst_pkg::DUR_W-1:0]  q_mem_r [fwst_pkg::QUEUE_DEPTH];
  logic [fwst_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fwst_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fwst_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        push;
  logic                        do_pop;

  // Disabled items are taken and dropped; enabled ones go to the queue
  assign in_tready = (count_r != fwst_pkg::QCNT_W'(fwst_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready && enable;
  assign do_pop    = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.dur   = q_mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == fwst_pkg::QPTR_W'(fwst_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fwst_pkg::QPTR_W'(fwst_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_dur;
    end
  end

endmodule

// ===== design/fwst_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Quotient must fit FPS_W bits. Depends on fwst_pkg.
module fwst_div #(
  parameter int SUM_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SUM_W-1:0]           dividend,
  input  logic [SUM_W-1:0]           divisor,
  output logic                       done,
  output logic [fwst_pkg::FPS_W-1:0] quotient
);

  localparam int STEP_W = $clog2(fwst_pkg::FPS_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [SUM_W:0]             rem_r, rem_nxt;
  logic [fwst_pkg::FPS_W-1:0] quo_r, quo_nxt;
  logic [SUM_W-1:0]           dvs_r, dvs_nxt;
  logic [SUM_W:0]             rem_sh;
  logic                       fits;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_r[SUM_W-1:0], quo_r[fwst_pkg::FPS_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = (SUM_W + 1)'(dividend >> fwst_pkg::FPS_W);
      quo_nxt  = dividend[fwst_pkg::FPS_W-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt  = {quo_r[fwst_pkg::FPS_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(fwst_pkg::FPS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

endmodule

// ===== design/fwst_back.sv =====
// Back end: history ring, interval timer, window walk and rate divisions.
// Depends on fwst_pkg and fwst_div.
module fwst_back #(
  parameter int HISTORY_DEPTH = fwst_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fwst_pkg::q_head_t          head,
  output logic                       pop,
  input  logic [fwst_pkg::DUR_W-1:0] interval,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output fwst_pkg::fps_report_t      report
);

  localparam int DEPTH_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W   = fwst_pkg::DUR_W + CNT_W;
  localparam int DUR_W   = fwst_pkg::DUR_W;
  localparam int FPS_W   = fwst_pkg::FPS_W;
  localparam int TIMER_W = fwst_pkg::TIMER_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_DSET = 5'b00100,
    ST_DRUN = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    JOB_CUR = 2'd0,
    JOB_AVG = 2'd1,
    JOB_MIN = 2'd2,
    JOB_MAX = 2'd3
  } job_t;

  state_t                state_r, state_nxt;
  job_t                  job_r, job_nxt, job_next;
  logic [DUR_W-1:0]      ring [HISTORY_DEPTH];
  logic [DEPTH_W-1:0]    wptr_r, wptr_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [TIMER_W-1:0]    timer_r, timer_nxt;
  logic [DUR_W-1:0]      last_r, last_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [DUR_W-1:0]      rd_data_r;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [DUR_W-1:0]      dmin_r, dmin_nxt;
  logic [DUR_W-1:0]      dmax_r, dmax_nxt;
  fwst_pkg::fps_report_t rep_r, rep_nxt;
  fwst_pkg::fps_report_t out_rep_r, out_rep_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  ring_we;
  logic [TIMER_W:0]      timer_sum;
  logic [TIMER_W-1:0]    timer_sat;
  logic                  div_start;
  logic [SUM_W-1:0]      div_dvd, div_dvs;
  logic                  div_done;
  logic [FPS_W-1:0]      div_quo;
  logic                  store_en;
  logic [FPS_W-1:0]      store_val;
  logic                  any_valid;
  logic                  out_load;

  fwst_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Saturating interval timer
  assign timer_sum = {1'b0, timer_r} + (TIMER_W + 1)'(head.dur);
  assign timer_sat = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];

  // Rate is monotonic in duration: min rate from longest, max from shortest
  assign any_valid = (dmax_r > fwst_pkg::VALID_MIN_US);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    case (job_r)
      JOB_CUR: job_next = JOB_AVG;
      JOB_AVG: job_next = JOB_MIN;
      JOB_MIN: job_next = JOB_MAX;
      default: job_next = JOB_MAX;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    timer_nxt     = timer_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    sum_nxt       = sum_r;
    dmin_nxt      = dmin_r;
    dmax_nxt      = dmax_r;
    rep_nxt       = rep_r;
    out_rep_nxt   = out_rep_r;
    out_valid_nxt = out_valid_r;
    ring_we       = 1'b0;
    pop           = 1'b0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    store_en      = 1'b0;
    store_val     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Take one duration: store it, advance pointers and timer; start a sweep once the interval is reached
      ST_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          ring_we  = 1'b1;
          last_nxt = head.dur;
          wptr_nxt = (wptr_r == DEPTH_W'(HISTORY_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
          if (fill_r < CNT_W'(HISTORY_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (timer_sat >= TIMER_W'(interval)) begin
            timer_nxt = '0;
            idx_nxt   = '0;
            sum_nxt   = '0;
            dmin_nxt  = '1;
            dmax_nxt  = '0;
            state_nxt = ST_WALK;
          end else begin
            timer_nxt = timer_sat;
          end
        end
      end

      // Sweep the written entries: sum, shortest and longest valid duration
      ST_WALK: begin
        if (idx_r < fill_r) begin
          idx_nxt    = idx_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(rd_data_r);
          if (rd_data_r > fwst_pkg::VALID_MIN_US) begin
            if (rd_data_r < dmin_r) dmin_nxt = rd_data_r;
            if (rd_data_r > dmax_r) dmax_nxt = rd_data_r;
          end
        end else if (idx_r == fill_r) begin
          job_nxt   = JOB_CUR;
          state_nxt = ST_DSET;
        end
      end

      // Set up the next division or take its fixed value
      ST_DSET: begin
        case (job_r)
          JOB_CUR: begin
            div_dvd   = SUM_W'(fwst_pkg::RATE_NUM);
            div_dvs   = SUM_W'(last_r);
            div_start = (last_r > fwst_pkg::VALID_MIN_US);
            store_val = '0;
          end
          JOB_AVG: begin
            div_dvd   = SUM_W'(fwst_pkg::RATE_NUM) * SUM_W'(fill_r);
            div_dvs   = sum_r;
            div_start = (sum_r > SUM_W'(fwst_pkg::VALID_MIN_US) * SUM_W'(fill_r));
            store_val = '0;
          end
          JOB_MIN: begin
            div_dvd   = SUM_W'(fwst_pkg::RATE_NUM);
            div_dvs   = SUM_W'(dmax_r);
            div_start = any_valid;
            store_val = fwst_pkg::MIN_NONE;
          end
          default: begin
            div_dvd   = SUM_W'(fwst_pkg::RATE_NUM);
            div_dvs   = SUM_W'(dmin_r);
            div_start = any_valid;
            store_val = '0;
          end
        endcase
        if (div_start) begin
          state_nxt = ST_DRUN;
        end else begin
          store_en = 1'b1;
        end
      end

      ST_DRUN: begin
        if (div_done) begin
          store_en  = 1'b1;
          store_val = div_quo;
        end
      end

      // Hand the report to the output register
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_rep_nxt   = rep_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Record one report field and move to the next job
    if (store_en) begin
      case (job_r)
        JOB_CUR: rep_nxt.current_fps = store_val;
        JOB_AVG: rep_nxt.average_fps = store_val;
        JOB_MIN: rep_nxt.min_fps     = store_val;
        default: rep_nxt.max_fps     = store_val;
      endcase
      if (job_r == JOB_MAX) begin
        state_nxt = ST_OUT;
      end else begin
        job_nxt   = job_next;
        state_nxt = ST_DSET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_CUR;
      wptr_r      <= '0;
      fill_r      <= '0;
      timer_r     <= '0;
      last_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      timer_r     <= timer_nxt;
      last_r      <= last_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    sum_r     <= sum_nxt;
    dmin_r    <= dmin_nxt;
    dmax_r    <= dmax_nxt;
    rep_r     <= rep_nxt;
    out_rep_r <= out_rep_nxt;
  end

  // History ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wptr_r] <= head.dur;
    end
    rd_data_r <= ring[idx_r[DEPTH_W-1:0]];
  end

  assign out_tvalid = out_valid_r;
  assign report     = out_rep_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(HISTORY_DEPTH))
    else $error("fill count beyond window depth");

  a_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (timer_r == '0))
    else $error("report issued with running timer");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DRUN))
    else $error("divider result outside of division state");

  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_WALK))
    else $error("ring read data outside of window sweep");

  a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid)
    else $error("loaded report not presented");

endmodule

// ===== design/frame_rate_window_stats.sv =====
// Top level of the frame-rate window statistics block.
// Holds the configuration registers; depends on fwst_pkg, fwst_front, fwst_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in_      | in_tvalid / in_tready   | in_tdata: frame_time_us[23:0]
//  out_     | out_tvalid / out_tready | out_tdata: current, average, min, max
//  cfg_     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A duration that does not close an interval passes through the queue and is then
// written to the ring. A reporting duration is swept one ring entry per cycle
// through the single read port, then takes up to four 18-step passes of the shared
// bit-serial divider, each with setup and hand-off.
// The ring needs no clearing after reset.
// The four-entry front queue keeps taking items while a report is worked out, until it is full.
module frame_rate_window_stats #(
  parameter int HISTORY_DEPTH = fwst_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: frame_time_us[23:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,
  // out_tdata: current_fps[17:0], average_fps[35:18], min_fps[53:36],
  //            max_fps[71:54]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [71:0]                       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fwst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [23:0]                       cfg_data
);

  logic                  enable_r, enable_nxt;
  logic [23:0]           interval_r, interval_nxt;
  fwst_pkg::q_head_t     head;
  logic                  pop;
  fwst_pkg::fps_report_t report;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    enable_nxt   = enable_r;
    interval_nxt = interval_r;
    if (cfg_valid) begin
      case (cfg_index)
        fwst_pkg::CFG_ENABLE:   enable_nxt   = cfg_data[0];
        fwst_pkg::CFG_INTERVAL: interval_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= fwst_pkg::ENABLE_RST;
      interval_r <= fwst_pkg::INTERVAL_RST;
    end else begin
      enable_r   <= enable_nxt;
      interval_r <= interval_nxt;
    end
  end

  fwst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_dur    (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  fwst_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .interval   (interval_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .report     (report)
  );

  assign out_tdata = report;

endmodule
